// ===== sv/twct_pkg.sv =====
package twct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int COUNT_W = 32;
    localparam int ACC_W   = 8;
    localparam int KEY_W   = 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic REQ_BLOCK  = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic KIND_WAKE = 1'b0;
    localparam logic KIND_FULL = 1'b1;

    // A classified request: the signed change to apply to the count and whether
    // the requesting accelerator becomes the waiter of the entry.
    typedef struct packed {
        logic               set_acc;
        logic [COUNT_W-1:0] delta;
        logic [ACC_W-1:0]   acc;
        logic [KEY_W-1:0]   key;
    } t_item;

endpackage

// ===== sv/twct_ifs.sv =====
interface twct_req_if import twct_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [COUNT_W-1:0] component_count;
    logic        [ACC_W-1:0]   requester_acc;
    logic        [KEY_W-1:0]   task_key;

    modport source (output valid, req_type, component_count, requester_acc, task_key,
                    input ready);
    modport sink   (input valid, req_type, component_count, requester_acc, task_key,
                    output ready);
endinterface

interface twct_rsp_if import twct_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             result_kind;
    logic [ACC_W-1:0] wake_acc;

    modport source (output valid, result_kind, wake_acc, input ready);
    modport sink   (input valid, result_kind, wake_acc, output ready);
endinterface

// ===== sv/twct_front.sv =====
module twct_front import twct_pkg::*; (
    twct_req_if.sink i_req,
    input  logic     i_space,
    output logic     o_push,
    output t_item    o_item
);

    logic is_block;

    assign is_block    = (i_req.req_type == REQ_BLOCK);
    assign i_req.ready = i_space;
    assign o_push      = i_req.valid && i_space;

    // A block request subtracts its count, so it is turned into a negated delta here.
    assign o_item.set_acc = is_block;
    assign o_item.delta   = is_block ? (COUNT_W'(0) - COUNT_W'(i_req.component_count))
                                     : COUNT_W'(i_req.component_count);
    assign o_item.acc     = i_req.requester_acc;
    assign o_item.key     = i_req.task_key;

endmodule

// ===== sv/twct_queue.sv =====
module twct_queue import twct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_space,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_space = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != QCNT_W'(0));
    assign o_item  = r_store[r_rd];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr] <= i_item;
        end
    end

endmodule

// ===== sv/twct_exec.sv =====
module twct_exec import twct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    twct_rsp_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_MATCH   = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;
    localparam logic [1:0] S_UPDATE  = 2'd3;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    t_item                    r_item;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]         r_task [TABLE_ENTRIES];
    logic [ACC_W-1:0]         r_acc_mem [TABLE_ENTRIES];
    logic [COUNT_W-1:0]       r_pend_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] r_match;
    logic [TABLE_ENTRIES-1:0] n_match;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    logic                     r_hit;
    logic                     n_hit;
    logic                     r_found;
    logic                     n_found;
    logic [ACC_W-1:0]         r_rd_acc;
    logic [COUNT_W-1:0]       r_rd_pend;

    logic                     r_out_valid;
    logic                     r_out_kind;
    logic [ACC_W-1:0]         r_out_acc;

    logic [COUNT_W-1:0]       pend_old;
    logic [COUNT_W-1:0]       pend_new;
    logic [ACC_W-1:0]         acc_eff;
    logic                     is_full;
    logic                     is_zero;
    logic                     need_out;
    logic                     advance;
    logic                     commit;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_match[i] = r_valid[i] && (r_task[i] == r_item.key);
        end
    end

    // Lowest matching entry wins; with no match, the lowest free entry is taken.
    always_comb begin
        n_hit   = 1'b0;
        n_found = 1'b0;
        n_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i] && !n_hit) begin
                n_found = 1'b1;
                n_idx   = IDX_W'(i);
            end
        end
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                n_hit = 1'b1;
                n_idx = IDX_W'(i);
            end
        end
        n_found = n_found || n_hit;
    end

    // A free entry is treated as holding a zero count, so a new task starts from zero.
    assign pend_old = r_hit ? r_rd_pend : '0;
    assign pend_new = pend_old + r_item.delta;
    assign acc_eff  = r_item.set_acc ? r_item.acc : r_rd_acc;
    assign is_full  = !r_found;
    assign is_zero  = (pend_new == '0);
    assign need_out = is_full || is_zero;
    assign advance  = !need_out || !r_out_valid || o_rsp.ready;
    assign commit   = (r_state == S_UPDATE) && advance && !is_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH:   n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_UPDATE;
            S_UPDATE: begin
                if (advance) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_valid[r_idx] <= !is_zero;
            end
            if ((r_state == S_UPDATE) && advance && need_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == S_MATCH) begin
            r_match <= n_match;
        end
        if (r_state == S_RESOLVE) begin
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_found   <= n_found;
            r_rd_acc  <= r_acc_mem[n_idx];
            r_rd_pend <= r_pend_mem[n_idx];
        end
        if (commit) begin
            r_task[r_idx]     <= r_item.key;
            r_acc_mem[r_idx]  <= acc_eff;
            r_pend_mem[r_idx] <= pend_new;
        end
        if ((r_state == S_UPDATE) && advance && need_out) begin
            r_out_kind <= is_full ? KIND_FULL : KIND_WAKE;
            r_out_acc  <= is_full ? '0 : acc_eff;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.wake_acc    = r_out_acc;

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPDATE))
        else $error("result raised outside the update step");

    a_hit_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_hit) |-> r_match[r_idx])
        else $error("selected entry does not match the key");

    a_wake_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && is_zero) |=> !r_valid[r_idx])
        else $error("entry still valid after wakeup");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && is_full && advance) |=> $stable(r_valid))
        else $error("table changed on a full result");

endmodule

// ===== sv/task_wait_counter_table_core.sv =====
// Channel  Dir  Handshake     Payload
// i_req    in   valid/ready   req_type, component_count, requester_acc, task_key
// o_rsp    out  valid/ready   result_kind, wake_acc
//
// Each request passes through four steps in the execution unit: queue pop, parallel tag
// compare, priority select with table read, and count update with write-back.
// A two-entry queue in front lets requests arrive while one is being worked on.
// Synchronous reset clears all entry valid bits directly; no clearing pass.
// A result waits in the output register; only the update step of an item that
// produces a result stalls while that register is still full.
module task_wait_counter_table_core import twct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twct_req_if.sink   i_req,
    twct_rsp_if.source o_rsp
);

    logic  front_push;
    t_item front_item;
    logic  q_space;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    twct_front u_front (
        .i_req   (i_req),
        .i_space (q_space),
        .o_push  (front_push),
        .o_item  (front_item)
    );

    twct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_space (q_space),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    twct_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import twct_pkg::*;

    localparam int RANDOM_REQUESTS = 925;
    localparam int HOLD_START      = 1500;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 32;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE} t_sink_mode;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] count;
        logic [ACC_W-1:0]   acc;
        logic [KEY_W-1:0]   key;
    } t_wait_req;

    typedef struct packed {
        logic             has;
        logic             blind;
        logic             kind;
        logic [ACC_W-1:0] acc;
    } t_wake;

    typedef struct packed {
        t_wait_req req;
        t_wake     outcome;
    } t_staged;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               src_valid = 1'b0;
    logic               src_type = 1'b0;
    logic [COUNT_W-1:0] src_count = '0;
    logic [ACC_W-1:0]   src_acc = '0;
    logic [KEY_W-1:0]   src_key = '0;
    logic               sink_ready = 1'b0;

    twct_req_if req_if ();
    twct_rsp_if rsp_if ();

    assign req_if.valid           = src_valid;
    assign req_if.req_type        = src_type;
    assign req_if.component_count = src_count;
    assign req_if.requester_acc   = src_acc;
    assign req_if.task_key        = src_key;
    assign rsp_if.ready           = sink_ready;

    task_wait_counter_table_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the wait table.
    logic               live [TABLE_ENTRIES];
    logic [KEY_W-1:0]   owner_key [TABLE_ENTRIES];
    logic [ACC_W-1:0]   waiter [TABLE_ENTRIES];
    logic               waiter_known [TABLE_ENTRIES];
    logic [COUNT_W-1:0] open_count [TABLE_ENTRIES];

    t_staged request_queue[$];
    t_wake   wake_expected[$];

    int total_requests = 0;
    int accepted = 0;
    int mismatches = 0;
    int wakes_seen = 0;
    int fulls_seen = 0;

    // Works out the outcome of one request; the table is updated only when commit is set.
    // A wakeup that would carry a waiter id never written is flagged as blind.
    function automatic t_wake resolve_request(input t_wait_req r, input bit commit);
        t_wake              res;
        int                 slot;
        logic [COUNT_W-1:0] pend;
        res  = '0;
        slot = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot < 0 && live[i] && owner_key[i] == r.key) slot = i;
        if (slot < 0)
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot < 0 && !live[i]) slot = i;
        if (slot < 0) begin
            res.has  = 1'b1;
            res.kind = KIND_FULL;
            return res;
        end
        pend = (r.req_type == REQ_BLOCK) ? open_count[slot] - r.count
                                         : open_count[slot] + r.count;
        if (pend == '0) begin
            res.has   = 1'b1;
            res.kind  = KIND_WAKE;
            res.acc   = (r.req_type == REQ_BLOCK) ? r.acc : waiter[slot];
            res.blind = (r.req_type != REQ_BLOCK) && !waiter_known[slot];
        end
        if (commit) begin
            owner_key[slot]  = r.key;
            if (r.req_type == REQ_BLOCK) begin
                waiter[slot]       = r.acc;
                waiter_known[slot] = 1'b1;
            end
            live[slot]       = (pend != '0);
            open_count[slot] = pend;
        end
        return res;
    endfunction

    task automatic stage_request(input logic kind, input logic [COUNT_W-1:0] count,
                                 input logic [ACC_W-1:0] acc, input logic [KEY_W-1:0] key);
        t_staged s;
        s.req.req_type = kind;
        s.req.count    = count;
        s.req.acc      = acc;
        s.req.key      = key;
        // A finish that would wake an accelerator never recorded becomes a block.
        s.outcome = resolve_request(s.req, 1'b0);
        if (s.outcome.blind) s.req.req_type = REQ_BLOCK;
        s.outcome = resolve_request(s.req, 1'b1);
        request_queue.push_back(s);
    endtask

    function automatic int pick_live_slot();
        int slots[$];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (live[i]) slots.push_back(i);
        if (slots.size() == 0) return -1;
        return slots[$urandom_range(slots.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        if ($urandom_range(1)) return {$urandom, $urandom};
        return KEY_W'($urandom_range(31));
    endfunction

    function automatic logic [COUNT_W-1:0] small_count();
        if ($urandom_range(15) == 0) return $urandom;
        return COUNT_W'($urandom_range(1, 4));
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    t_staged head;
    t_staged done;
    logic    took;
    logic    offer;
    int      burst_left = 8;
    int      gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            took = src_valid && req_if.ready;
            if (took) begin
                done = request_queue.pop_front();
                if (done.outcome.has) wake_expected.push_back(done.outcome);
                accepted++;
            end
            if (!src_valid || took) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_queue.size() > 0) begin
                    offer     = 1'b1;
                    head      = request_queue[0];
                    src_type  <= head.req.req_type;
                    src_count <= head.req.count;
                    src_acc   <= head.req.acc;
                    src_key   <= head.req.key;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
                src_valid <= offer;
            end
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    int   hold_clock = 0;
    logic hold_off = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_clock <= 0;
            hold_off   <= 1'b0;
        end else begin
            hold_clock <= hold_clock + 1;
            hold_off   <= (hold_clock >= HOLD_START) && (hold_clock < HOLD_START + HOLD_CYCLES);
        end
    end

    t_sink_mode sink_mode = SINK_OPEN;
    int         mode_left = 0;
    logic       sink_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(2));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (sink_mode)
                SINK_OPEN:   sink_next = 1'b1;
                SINK_COIN:   sink_next = 1'($urandom_range(1));
                default:     sink_next = ($urandom_range(3) == 0);
            endcase
            sink_ready <= sink_next && !hold_off;
        end
    end

    // Result monitor.
    t_wake want;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_if.result_kind == KIND_FULL) fulls_seen++;
            else wakes_seen++;
            if (wake_expected.size() == 0) begin
                $error("unexpected result: result_kind %0d wake_acc 0x%0h",
                       rsp_if.result_kind, rsp_if.wake_acc);
                mismatches++;
            end else begin
                want = wake_expected.pop_front();
                if (rsp_if.result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, rsp_if.result_kind);
                    mismatches++;
                end
                if (rsp_if.wake_acc !== want.acc) begin
                    $error("wake_acc: expected 0x%0h, got 0x%0h", want.acc, rsp_if.wake_acc);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("Timeout with %0d of %0d requests accepted", accepted, total_requests);
        $display("Mismatches found");
        $finish;
    end

    int                 slot;
    int                 pick;
    logic [COUNT_W-1:0] need;

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            live[i]         = 1'b0;
            owner_key[i]    = '0;
            waiter[i]       = '0;
            waiter_known[i] = 1'b0;
            open_count[i]   = '0;
        end

        // Immediate wakeup, then a finish on a freed entry that keeps its old waiter.
        stage_request(REQ_BLOCK, '0, 8'hFF, 64'h0);
        stage_request(REQ_FINISH, '0, 8'h00, 64'h1);
        stage_request(REQ_BLOCK, 32'd3, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
        stage_request(REQ_FINISH, 32'd3, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // Children finish before the parent starts to wait.
        stage_request(REQ_FINISH, 32'd7, 8'h33, 64'h5555_5555_5555_5555);
        stage_request(REQ_BLOCK, 32'd7, 8'hA5, 64'h5555_5555_5555_5555);
        // Most negative count: the sum wraps back to zero.
        stage_request(REQ_BLOCK, 32'h8000_0000, 8'h5A, 64'hAAAA_AAAA_AAAA_AAAA);
        stage_request(REQ_FINISH, 32'h8000_0000, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA);
        // Fill every entry, then one more task has nowhere to go.
        for (int i = 0; i < TABLE_ENTRIES; i++)
            stage_request(REQ_BLOCK, 32'd1, ACC_W'(i * 17), KEY_W'(256 + i));
        stage_request(REQ_BLOCK, 32'd1, 8'h3C, 64'hDEAD_BEEF_0000_0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            slot = pick_live_slot();
            pick = $urandom_range(99);
            if (pick < 45 && slot >= 0) begin
                need = -open_count[slot];
                stage_request(REQ_FINISH,
                              $urandom_range(1) ? need : COUNT_W'($urandom_range(1, 3)),
                              ACC_W'($urandom_range(255)), owner_key[slot]);
            end else if (pick < 60 && slot >= 0) begin
                stage_request(REQ_BLOCK,
                              ($urandom_range(2) != 0) ? open_count[slot] : small_count(),
                              ACC_W'($urandom_range(255)), owner_key[slot]);
            end else if (pick < 80) begin
                stage_request(REQ_BLOCK, small_count(), ACC_W'($urandom_range(255)),
                              fresh_key());
            end else if (pick < 90) begin
                stage_request(REQ_FINISH, small_count(), ACC_W'($urandom_range(255)),
                              fresh_key());
            end else begin
                stage_request(1'($urandom_range(1)), $urandom, ACC_W'($urandom_range(255)),
                              (slot >= 0 && $urandom_range(1)) ? owner_key[slot]
                                                               : {$urandom, $urandom});
            end
        end
        total_requests = request_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total_requests || wake_expected.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d block and finish requests: %0d wakeups, %0d table-full results,",
                 total_requests, wakes_seen, fulls_seen);
        $display("with random sender gaps, receiver stalls and one long receiver hold-off.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
